// ----- rtl/kde_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kde_pkg
// Shared types and constants for the keypad decimal entry block.
// ----------------------------------------------------------------------------
package kde_pkg;

    localparam int ENTRY_LENGTH_DEF = 16;

    localparam int KEY_W   = 5;
    localparam int DIGIT_W = 4;
    localparam int ACT_W   = 2;
    localparam int CHAR_W  = 6;
    localparam int POS_W   = 4;
    localparam int ACC_W   = 54;
    localparam int FRAC_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [KEY_W-1:0] KEY_LAST_DIGIT = KEY_W'(9);
    localparam logic [KEY_W-1:0] KEY_POINT      = KEY_W'(10);
    localparam logic [KEY_W-1:0] ENTER_RESET    = KEY_W'(11);
    localparam logic [KEY_W-1:0] DELETE_RESET   = KEY_W'(12);

    localparam logic [CFG_IDX_W-1:0] REG_ENTER_KEY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DELETE_KEY = 1'b1;

    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ERASE = 2'd2;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 6'h20;
    localparam logic [CHAR_W-1:0] CH_POINT = 6'h2E;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_DIGIT,
        CMD_POINT,
        CMD_ENTER,
        CMD_DELETE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        logic [DIGIT_W-1:0]  digit;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
        logic              done;
        logic [ACC_W-1:0]  mantissa;
        logic [FRAC_W-1:0] frac;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/keypad_decimal_entry_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_decimal_entry_top
// Builds an exact decimal number from keypad codes, one echo item per key.
// ----------------------------------------------------------------------------
// Takes one key item per clock while full is low and returns one result
// item per key. A pushed key is classified against the enter/delete
// registers and queued; when it fires, the entry logic updates all state
// (shift-add times ten, delete restores a saved per-column mantissa) and
// writes the result to the result queue, from which it is popped.
// Sustained rate is one item per cycle while neither queue stalls.
// Two-entry queues sit between the classifier and the entry logic and on
// the result side, so either end may stall briefly without halting the
// other. Write the key-code registers only while no key is in flight.
module keypad_decimal_entry_top
    import kde_pkg::*;
#(
    parameter int ENTRY_LENGTH = ENTRY_LENGTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [KEY_W-1:0]     i_cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [KEY_W-1:0]     i_key_code,
    input  wire logic                 pop,
    output logic                      empty,
    output logic [ACT_W-1:0]          o_echo_action,
    output logic [CHAR_W-1:0]         o_echo_char,
    output logic [POS_W-1:0]          o_echo_position,
    output logic                      o_number_done,
    output logic [ACC_W-1:0]          o_mantissa,
    output logic [FRAC_W-1:0]         o_fraction_digits
);

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_result);

    t_cmd    front_cmd;
    t_cmd    back_cmd;
    t_result back_res;
    t_result out_res;
    logic    cmd_empty;
    logic    res_full;
    logic    fire;

    assign o_cfg_ready = 1'b1;
    assign fire = !cmd_empty && !res_full;

    kde_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_key_code  (i_key_code),
        .o_cmd       (front_cmd)
    );

    kde_queue #(.W(CMD_W)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (fire),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    kde_back #(.ENTRY_LENGTH(ENTRY_LENGTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cmd   (back_cmd),
        .o_res   (back_res)
    );

    kde_queue #(.W(RES_W)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_echo_action     = out_res.action;
    assign o_echo_char       = out_res.ch;
    assign o_echo_position   = out_res.pos;
    assign o_number_done     = out_res.done;
    assign o_mantissa        = out_res.mantissa;
    assign o_fraction_digits = out_res.frac;

endmodule
`default_nettype wire

// ----- rtl/kde_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kde_queue
// Two-entry register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module kde_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wptr, n_wptr;
    logic         r_rptr, n_rptr;
    logic [1:0]   r_count, n_count;
    logic         do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr ^ do_push;
        n_rptr  = r_rptr ^ do_pop;
        n_count = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/kde_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kde_front
// Holds the key-code registers and sorts each key into a command.
// ----------------------------------------------------------------------------
module kde_front
    import kde_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [KEY_W-1:0]     i_cfg_data,
    input  wire logic [KEY_W-1:0]     i_key_code,
    output t_cmd                      o_cmd
);

    logic [KEY_W-1:0] r_enter_key;
    logic [KEY_W-1:0] r_delete_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_key  <= ENTER_RESET;
            r_delete_key <= DELETE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENTER_KEY:  r_enter_key  <= i_cfg_data;
                REG_DELETE_KEY: r_delete_key <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // digits and the point win over both registers, enter wins over delete
    always_comb begin
        o_cmd.digit = i_key_code[DIGIT_W-1:0];
        priority if (i_key_code <= KEY_LAST_DIGIT) begin
            o_cmd.kind = CMD_DIGIT;
        end else if (i_key_code == KEY_POINT) begin
            o_cmd.kind = CMD_POINT;
        end else if (i_key_code == r_enter_key) begin
            o_cmd.kind = CMD_ENTER;
        end else if (i_key_code == r_delete_key) begin
            o_cmd.kind = CMD_DELETE;
        end else begin
            o_cmd.kind = CMD_NONE;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/kde_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kde_back
// Entry state: cursor, point tracking, running mantissa and the echo result.
// ----------------------------------------------------------------------------
module kde_back
    import kde_pkg::*;
#(
    parameter int ENTRY_LENGTH = ENTRY_LENGTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire t_cmd i_cmd,
    output t_result   o_res
);

    localparam int CUR_W = $clog2(ENTRY_LENGTH + 1);
    localparam int IDX_W = $clog2(ENTRY_LENGTH);
    localparam logic [CUR_W-1:0] CUR_LAST = CUR_W'(ENTRY_LENGTH - 1);

    logic [CUR_W-1:0]  r_cursor, n_cursor;
    logic              r_point_seen, n_point_seen;
    logic [POS_W-1:0]  r_point_index, n_point_index;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [FRAC_W-1:0] r_frac, n_frac;

    // mantissa before the character at each column; a delete restores it,
    // which equals the running value divided by ten
    logic [ACC_W-1:0]  r_save [ENTRY_LENGTH];
    logic              save_we;
    logic [CUR_W-1:0]  prev_cur;
    logic              room;
    logic              done;

    assign prev_cur = r_cursor - CUR_W'(1);
    assign room     = (r_cursor <= CUR_LAST);

    always_comb begin
        n_cursor      = r_cursor;
        n_point_seen  = r_point_seen;
        n_point_index = r_point_index;
        n_acc         = r_acc;
        n_frac        = r_frac;
        save_we       = 1'b0;
        done          = 1'b0;
        o_res.action   = ACT_NONE;
        o_res.ch       = CH_SPACE;
        o_res.pos      = '0;
        o_res.mantissa = '0;
        o_res.frac     = '0;

        unique case (i_cmd.kind)
            CMD_DIGIT: begin
                if (room) begin
                    o_res.action = ACT_WRITE;
                    o_res.ch     = CH_ZERO | CHAR_W'(i_cmd.digit);
                    o_res.pos    = POS_W'(r_cursor);
                    save_we      = 1'b1;
                    n_acc = {r_acc[ACC_W-4:0], 3'b000} + {r_acc[ACC_W-2:0], 1'b0}
                          + ACC_W'(i_cmd.digit);
                    if (r_point_seen) begin
                        n_frac = r_frac + FRAC_W'(1);
                    end
                    n_cursor = r_cursor + CUR_W'(1);
                    done     = (r_cursor == CUR_LAST);
                end
            end
            CMD_POINT: begin
                if (room && !r_point_seen) begin
                    o_res.action  = ACT_WRITE;
                    o_res.ch      = CH_POINT;
                    o_res.pos     = POS_W'(r_cursor);
                    save_we       = 1'b1;
                    n_point_seen  = 1'b1;
                    n_point_index = POS_W'(r_cursor);
                    n_cursor      = r_cursor + CUR_W'(1);
                    done          = (r_cursor == CUR_LAST);
                end
            end
            CMD_ENTER: begin
                done = (r_cursor != '0);
            end
            CMD_DELETE: begin
                if (r_cursor != '0) begin
                    n_cursor     = prev_cur;
                    o_res.action = ACT_ERASE;
                    o_res.pos    = POS_W'(prev_cur);
                    if (r_point_seen && r_point_index == POS_W'(prev_cur)) begin
                        n_point_seen  = 1'b0;
                        n_point_index = '0;
                    end else begin
                        n_acc = r_save[IDX_W'(prev_cur)];
                        if (r_point_seen && r_frac != '0) begin
                            n_frac = r_frac - FRAC_W'(1);
                        end
                    end
                end
            end
            CMD_NONE: ;
            default: ;
        endcase

        o_res.done = done;
        if (done) begin
            o_res.mantissa = n_acc;
            o_res.frac     = n_frac;
            n_cursor      = '0;
            n_point_seen  = 1'b0;
            n_point_index = '0;
            n_acc         = '0;
            n_frac        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor      <= '0;
            r_point_seen  <= 1'b0;
            r_point_index <= '0;
            r_acc         <= '0;
            r_frac        <= '0;
        end else if (i_fire) begin
            r_cursor      <= n_cursor;
            r_point_seen  <= n_point_seen;
            r_point_index <= n_point_index;
            r_acc         <= n_acc;
            r_frac        <= n_frac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && save_we) begin
            r_save[IDX_W'(r_cursor)] <= r_acc;
        end
    end

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keypad_decimal_entry_top. A directed key table,
// then random key streams under several key-code settings and flow-control
// patterns; each echo item is checked against its row or an entry predictor.
// ----------------------------------------------------------------------------
module tb;
    import kde_pkg::*;

    localparam int N_ROWS        = 15;
    localparam int N_PHASES      = 8;
    localparam int KEYS_PER_PHASE = 225;
    localparam int HOLD_CYCLES   = 80;
    localparam int QUIET_LIMIT   = 2000;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [4:0]       reps;
        logic             typed;
        t_result          res;
    } t_key_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [KEY_W-1:0]     i_cfg_data;
    logic                 push;
    logic                 full;
    logic [KEY_W-1:0]     i_key_code;
    logic                 pop;
    logic                 empty;
    logic [ACT_W-1:0]     o_echo_action;
    logic [CHAR_W-1:0]    o_echo_char;
    logic [POS_W-1:0]     o_echo_position;
    logic                 o_number_done;
    logic [ACC_W-1:0]     o_mantissa;
    logic [FRAC_W-1:0]    o_fraction_digits;

    // entry predictor state and key-code registers
    logic [4:0]        cur;
    logic              pt_seen;
    logic [3:0]        pt_col;
    logic [ACC_W-1:0]  acc;
    logic [FRAC_W-1:0] frac_cnt;
    logic [KEY_W-1:0]  enter_code;
    logic [KEY_W-1:0]  delete_code;
    logic              long_entry;

    t_result  echo_q[$];
    t_result  want;
    t_key_row key_rows[N_ROWS];

    int mismatches;
    int quiet_cycles;
    int send_idle_pct;
    int stall_pct;
    bit hold_req;
    int hold_left;

    int phase_enter[N_PHASES]  = '{11, 19, 15, 13, 11, 19, 17, 12};
    int phase_delete[N_PHASES] = '{12, 11, 15, 18, 19, 19, 14, 11};

    keypad_decimal_entry_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_key_code       (i_key_code),
        .pop              (pop),
        .empty            (empty),
        .o_echo_action    (o_echo_action),
        .o_echo_char      (o_echo_char),
        .o_echo_position  (o_echo_position),
        .o_number_done    (o_number_done),
        .o_mantissa       (o_mantissa),
        .o_fraction_digits(o_fraction_digits)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_entry();
        cur      = '0;
        pt_seen  = 1'b0;
        pt_col   = '0;
        acc      = '0;
        frac_cnt = '0;
    endfunction

    function automatic t_result predict_key(input logic [KEY_W-1:0] key);
        t_result r;
        logic    done;
        r        = '0;
        r.action = ACT_NONE;
        r.ch     = CH_SPACE;
        done     = 1'b0;
        if (key <= KEY_POINT) begin
            if (key == KEY_POINT && pt_seen) begin
                // second point: ignored
            end else if (cur < ENTRY_LENGTH_DEF) begin
                r.action = ACT_WRITE;
                r.pos    = cur[3:0];
                if (key == KEY_POINT) begin
                    r.ch    = CH_POINT;
                    pt_seen = 1'b1;
                    pt_col  = cur[3:0];
                end else begin
                    r.ch = CH_ZERO | {1'b0, key};
                    acc  = acc * 54'd10 + ACC_W'(key);
                    if (pt_seen)
                        frac_cnt = frac_cnt + FRAC_W'(1);
                end
                cur = cur + 5'd1;
                if (cur >= ENTRY_LENGTH_DEF)
                    done = 1'b1;
            end
        end else if (key == enter_code) begin
            if (cur != 0)
                done = 1'b1;
        end else if (key == delete_code) begin
            if (cur != 0) begin
                cur      = cur - 5'd1;
                r.action = ACT_ERASE;
                r.ch     = CH_SPACE;
                r.pos    = cur[3:0];
                if (pt_seen && {1'b0, pt_col} == cur) begin
                    pt_seen = 1'b0;
                    pt_col  = '0;
                end else begin
                    acc = acc / 54'd10;
                    if (pt_seen && frac_cnt != 0)
                        frac_cnt = frac_cnt - FRAC_W'(1);
                end
            end
        end
        if (done) begin
            r.done     = 1'b1;
            r.mantissa = acc;
            r.frac     = frac_cnt;
            clear_entry();
        end
        return r;
    endfunction

    // Mostly well-formed entries; some long ones that run to a full buffer.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        if (cur == 0)
            long_entry = ($urandom_range(3) == 0);
        if (cur == 0 && long_entry && $urandom_range(2) == 0)
            return KEY_POINT;
        r = $urandom_range(99);
        if (r < 55)
            return KEY_W'($urandom_range(9));
        if (r < 63)
            return KEY_POINT;
        if (r < 73)
            return delete_code;
        if (r < 73 + (long_entry ? 1 : 10))
            return enter_code;
        if (r < 92)
            return KEY_W'($urandom_range(19, 11));
        return KEY_W'($urandom_range(19));
    endfunction

    function automatic t_key_row make_row(input logic [KEY_W-1:0] key, input int reps,
                                          input logic typed, input logic [ACT_W-1:0] act,
                                          input logic [CHAR_W-1:0] ch,
                                          input logic [POS_W-1:0] pos, input logic done,
                                          input logic [ACC_W-1:0] mant,
                                          input logic [FRAC_W-1:0] frac);
        t_key_row row;
        row.key          = key;
        row.reps         = 5'(reps);
        row.typed        = typed;
        row.res.action   = act;
        row.res.ch       = ch;
        row.res.pos      = pos;
        row.res.done     = done;
        row.res.mantissa = mant;
        row.res.frac     = frac;
        return row;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
        mismatches++;
    endtask

    task automatic send_key(input logic [KEY_W-1:0] key, input logic typed,
                            input t_result typed_res);
        bit      idle;
        t_result predicted;
        do begin
            @(negedge i_clk);
            idle = ($urandom_range(99) < send_idle_pct);
            if (idle) begin
                push <= 1'b0;
            end else begin
                push       <= 1'b1;
                i_key_code <= key;
            end
        end while (idle);
        forever begin
            @(posedge i_clk);
            if (!full)
                break;
        end
        predicted = predict_key(key);
        echo_q.push_back(typed ? typed_res : predicted);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= KEY_W'(data);
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        if (idx == REG_ENTER_KEY)
            enter_code = KEY_W'(data);
        else
            delete_code = KEY_W'(data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (echo_q.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // the receiver makes random stalls plus one long hold-off in the first phase
    initial begin
        pop       = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("keypad_decimal_entry_top verification failed");
                $finish;
            end
            if (pop && !empty) begin
                if (echo_q.size() == 0) begin
                    flag_mismatch("result with nothing pending", 64'(o_echo_action), 0);
                end else begin
                    want = echo_q.pop_front();
                    if (o_echo_action !== want.action)
                        flag_mismatch("echo_action", 64'(o_echo_action), 64'(want.action));
                    if (o_echo_char !== want.ch)
                        flag_mismatch("echo_char", 64'(o_echo_char), 64'(want.ch));
                    if (o_echo_position !== want.pos)
                        flag_mismatch("echo_position", 64'(o_echo_position), 64'(want.pos));
                    if (o_number_done !== want.done)
                        flag_mismatch("number_done", 64'(o_number_done), 64'(want.done));
                    if (o_mantissa !== want.mantissa)
                        flag_mismatch("mantissa", 64'(o_mantissa), 64'(want.mantissa));
                    if (o_fraction_digits !== want.frac)
                        flag_mismatch("fraction_digits", 64'(o_fraction_digits),
                                      64'(want.frac));
                end
            end
        end
    end

    initial begin
        int       i;
        int       j;
        int       p;
        t_result  no_res;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_ENTER_KEY;
        i_cfg_data    = '0;
        push          = 1'b0;
        i_key_code    = '0;
        mismatches    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        long_entry    = 1'b0;
        no_res        = '0;
        enter_code    = ENTER_RESET;
        delete_code   = DELETE_RESET;
        clear_entry();

        // directed keys under the reset key codes (enter 11, delete 12)
        key_rows[0]  = make_row(5'd11, 1, 1, ACT_NONE, CH_SPACE, 0, 0, 0, 0);
        key_rows[1]  = make_row(5'd12, 1, 1, ACT_NONE, CH_SPACE, 0, 0, 0, 0);
        key_rows[2]  = make_row(5'd19, 1, 1, ACT_NONE, CH_SPACE, 0, 0, 0, 0);
        key_rows[3]  = make_row(5'd0, 1, 1, ACT_WRITE, CH_ZERO, 0, 0, 0, 0);
        key_rows[4]  = make_row(5'd9, 1, 1, ACT_WRITE, 6'h39, 1, 0, 0, 0);
        key_rows[5]  = make_row(KEY_POINT, 1, 1, ACT_WRITE, CH_POINT, 2, 0, 0, 0);
        key_rows[6]  = make_row(KEY_POINT, 1, 1, ACT_NONE, CH_SPACE, 0, 0, 0, 0);
        key_rows[7]  = make_row(5'd5, 1, 0, ACT_NONE, CH_SPACE, 0, 0, 0, 0);
        key_rows[8]  = make_row(5'd12, 1, 1, ACT_ERASE, CH_SPACE, 3, 0, 0, 0);
        key_rows[9]  = make_row(5'd12, 1, 1, ACT_ERASE, CH_SPACE, 2, 0, 0, 0);
        key_rows[10] = make_row(5'd11, 1, 0, ACT_NONE, CH_SPACE, 0, 0, 0, 0);
        key_rows[11] = make_row(KEY_POINT, 1, 0, ACT_NONE, CH_SPACE, 0, 0, 0, 0);
        key_rows[12] = make_row(5'd11, 1, 1, ACT_NONE, CH_SPACE, 0, 1, 0, 0);
        key_rows[13] = make_row(5'd9, 15, 0, ACT_NONE, CH_SPACE, 0, 0, 0, 0);
        key_rows[14] = make_row(5'd9, 1, 1, ACT_WRITE, 6'h39, 15, 1,
                                54'd9999999999999999, 0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_ROWS; i++)
            for (j = 0; j < key_rows[i].reps; j++)
                send_key(key_rows[i].key, key_rows[i].typed && (j == key_rows[i].reps - 1),
                         key_rows[i].res);
        wait_for_drain();

        for (p = 0; p < N_PHASES; p++) begin
            write_reg(REG_ENTER_KEY, phase_enter[p]);
            write_reg(REG_DELETE_KEY, phase_delete[p]);
            unique case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 87; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 87; end
                default: begin send_idle_pct = 17; stall_pct = 17; end
            endcase
            // fill the block against a parked receiver
            if (p == 0)
                hold_req = 1'b1;
            for (i = 0; i < KEYS_PER_PHASE; i++)
                send_key(pick_key(), 1'b0, no_res);
            wait_for_drain();
        end

        if (mismatches == 0)
            $display("keypad_decimal_entry_top verification clean");
        else
            $display("keypad_decimal_entry_top verification failed");
        $finish;
    end

endmodule
